/* hw/rtl/sitda_pkg.sv */
`default_nettype none

package sitda_pkg;

	// Width of the magnitude that enters the BCD conversion.
	localparam int MAG_W = 32;

	// Shift-and-add-3 steps done in each conversion stage.
	localparam int BITS_PER_STAGE = 4;

	// ASCII codes that are not digits, and the code of digit zero.
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_POINT = 7'h2E;

	// Per-word flags that travel with the conversion pipeline.
	typedef struct packed {
		logic       neg;
		logic       zero;
		logic [2:0] frac;
	} sitda_ctl_t;

	// Formatting flags handed to the character emitter.
	typedef struct packed {
		logic neg;
		logic pt_ok;
	} sitda_fmt_t;

	// Power of ten, evaluated at elaboration only.
	function automatic longint unsigned pow10(input int n);
		longint unsigned acc;
		acc = 1;
		for (int i = 0; i < n; i++) begin
			acc = acc * 10;
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sitda_dabble_stage.sv */
`default_nettype none

module sitda_dabble_stage
	import sitda_pkg::*;
#(
	parameter int DIGITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [4*DIGITS-1:0]   in_bcd,
	input  wire logic [MAG_W-1:0]      in_bin,
	input  wire sitda_ctl_t            in_ctl,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [4*DIGITS-1:0]   out_bcd,
	output logic      [MAG_W-1:0]      out_bin,
	output sitda_ctl_t                 out_ctl
);

	logic                v_s1;
	logic [4*DIGITS-1:0] bcd_s1;
	logic [MAG_W-1:0]    bin_s1;
	sitda_ctl_t          ctl_s1;
	logic [4*DIGITS-1:0] bcd_n;
	logic [MAG_W-1:0]    bin_n;

	// BITS_PER_STAGE shift-and-add-3 steps: correct every BCD digit, then shift one binary bit in.
	always_comb begin
		bcd_n = in_bcd;
		bin_n = in_bin;
		for (int s = 0; s < BITS_PER_STAGE; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_n[4*d +: 4] >= 4'd5) begin
					bcd_n[4*d +: 4] = bcd_n[4*d +: 4] + 4'd3;
				end
			end
			{bcd_n, bin_n} = {bcd_n[4*DIGITS-2:0], bin_n, 1'b0};
		end
	end

	assign in_ready = !v_s1 || out_ready;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_s1 <= bcd_n;
			bin_s1 <= bin_n;
			ctl_s1 <= in_ctl;
		end
	end

	assign out_valid = v_s1;
	assign out_bcd   = bcd_s1;
	assign out_bin   = bin_s1;
	assign out_ctl   = ctl_s1;

endmodule

`default_nettype wire

/* hw/rtl/sitda_emitter.sv */
`default_nettype none

module sitda_emitter
	import sitda_pkg::*;
#(
	parameter int DIGITS = 8,
	parameter int IDX_W  = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [4*DIGITS-1:0] in_digits,
	input  wire sitda_fmt_t          in_fmt,
	input  wire logic [IDX_W-1:0]    in_start,
	input  wire logic [IDX_W-1:0]    in_point,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [6:0]          out_char,
	output logic                     out_last
);

	localparam logic [1:0] PH_SIGN  = 2'd0;
	localparam logic [1:0] PH_DIGIT = 2'd1;
	localparam logic [1:0] PH_POINT = 2'd2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

	logic             busy_q;
	logic [1:0]       phase_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] pt_q;
	logic             pt_ok_q;
	logic [3:0]       dig_q [DIGITS];
	logic             out_v_q;
	logic [6:0]       char_q;
	logic             last_q;

	logic             take;
	logic             at_point;
	logic [6:0]       ch;
	logic             lst;
	logic [1:0]       nphase;
	logic [IDX_W-1:0] npos;

	// A character leaves the sequencer whenever the output register can take it.
	assign take     = busy_q && (!out_v_q || !out_stall);
	assign at_point = pt_ok_q && (pos_q == pt_q);
	assign in_ready = !busy_q || (take && lst);

	// Character of the current phase and the step to the next one.
	always_comb begin
		unique case (phase_q)
			PH_SIGN: begin
				ch     = CHAR_MINUS;
				lst    = 1'b0;
				nphase = PH_DIGIT;
				npos   = pos_q;
			end
			PH_DIGIT: begin
				ch     = CHAR_ZERO + {3'b000, dig_q[pos_q]};
				lst    = (pos_q == LAST_IDX);
				nphase = at_point ? PH_POINT : PH_DIGIT;
				npos   = at_point ? pos_q : pos_q + 1'b1;
			end
			PH_POINT: begin
				ch     = CHAR_POINT;
				lst    = 1'b0;
				nphase = PH_DIGIT;
				npos   = pos_q + 1'b1;
			end
			default: begin
				ch     = CHAR_ZERO;
				lst    = 1'b1;
				nphase = PH_DIGIT;
				npos   = pos_q;
			end
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_DIGIT;
			pos_q   <= '0;
		end else if (in_valid && in_ready) begin
			busy_q  <= 1'b1;
			phase_q <= in_fmt.neg ? PH_SIGN : PH_DIGIT;
			pos_q   <= in_start;
		end else if (take && lst) begin
			busy_q  <= 1'b0;
		end else if (take) begin
			phase_q <= nphase;
			pos_q   <= npos;
		end
	end

	// Digits and point position of the word being printed.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pt_q    <= in_point;
			pt_ok_q <= in_fmt.pt_ok;
			for (int i = 0; i < DIGITS; i++) begin
				dig_q[i] <= in_digits[4*(DIGITS-1-i) +: 4];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= ch;
			last_q <= lst;
		end
	end

	assign out_valid = out_v_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii_core.sv */
// A taken word passes the front stage, the 8 conversion stages, the format stage, the
// sequencer and the output register before its first character is on dst_valid.
// Throughput: one character per cycle while dst_stall is low; a word is 1 to DECIMAL_DIGITS + 2
// characters long. The 8-stage BCD conversion pipeline holds further words meanwhile.
// Reset (arst_n low) clears all valid bits and the sequencer; payload is not reset.
`default_nettype none

module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
#(
	parameter int DECIMAL_DIGITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [31:0] value,
	input  wire logic [2:0]  fraction_digits,
	output logic             dst_valid,
	input  wire logic        dst_stall,
	output logic      [6:0]  char_code,
	output logic             last_char
);

	localparam int NSTG = MAG_W / BITS_PER_STAGE;
	localparam int IDX_W = (DECIMAL_DIGITS > 1) ? $clog2(DECIMAL_DIGITS) : 1;
	localparam int BCD_W = 4 * DECIMAL_DIGITS;
	localparam logic [MAG_W+1:0] LIMIT = (MAG_W + 2)'(pow10(DECIMAL_DIGITS) - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DECIMAL_DIGITS - 1);

	// Front stage: magnitude, sign and saturation.
	logic             v_s0;
	logic [MAG_W-1:0] mag_s0;
	sitda_ctl_t       ctl_s0;
	logic             rdy_s0;
	logic [MAG_W-1:0] mag_abs;
	logic [MAG_W-1:0] mag_sat;

	// Conversion chain.
	logic             v_c   [NSTG+1];
	logic             rdy_c [NSTG+1];
	logic [BCD_W-1:0] bcd_c [NSTG+1];
	logic [MAG_W-1:0] bin_c [NSTG+1];
	sitda_ctl_t       ctl_c [NSTG+1];

	// Format stage.
	logic             v_s9;
	logic [BCD_W-1:0] dig_s9;
	sitda_fmt_t       fmt_s9;
	logic [IDX_W-1:0] st_s9;
	logic [IDX_W-1:0] pt_s9;
	logic             rdy_s9;
	logic             em_ready;
	logic [IDX_W-1:0] first_idx;
	logic             pt_ok;
	logic [IDX_W-1:0] pt_idx;
	logic [IDX_W-1:0] st_idx;

	// Two's-complement magnitude, clipped to the widest printable value.
	always_comb begin
		mag_abs = value[31] ? (~value + 32'd1) : value;
		mag_sat = ({2'b00, mag_abs} > LIMIT) ? LIMIT[MAG_W-1:0] : mag_abs;
	end

	assign rdy_s0    = !v_s0 || rdy_c[0];
	assign src_stall = !rdy_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (rdy_s0) begin
			v_s0 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && rdy_s0) begin
			mag_s0      <= mag_sat;
			ctl_s0.neg  <= value[31];
			ctl_s0.zero <= (value == 32'd0);
			ctl_s0.frac <= fraction_digits;
		end
	end

	assign v_c[0]   = v_s0;
	assign bcd_c[0] = '0;
	assign bin_c[0] = mag_s0;
	assign ctl_c[0] = ctl_s0;
	assign rdy_c[NSTG] = rdy_s9;

	// Binary to BCD conversion, BITS_PER_STAGE bits per stage.
	for (genvar g = 0; g < NSTG; g++) begin : g_dabble
		sitda_dabble_stage #(
			.DIGITS(DECIMAL_DIGITS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_c[g]),
			.in_ready (rdy_c[g]),
			.in_bcd   (bcd_c[g]),
			.in_bin   (bin_c[g]),
			.in_ctl   (ctl_c[g]),
			.out_valid(v_c[g+1]),
			.out_ready(rdy_c[g+1]),
			.out_bcd  (bcd_c[g+1]),
			.out_bin  (bin_c[g+1]),
			.out_ctl  (ctl_c[g+1])
		);
	end

	// First printed digit and point position; a word with no digit before the point
	// starts at the point digit, which is then a zero.
	always_comb begin
		first_idx = LAST_IDX;
		for (int i = DECIMAL_DIGITS - 1; i >= 0; i--) begin
			if (bcd_c[NSTG][4*(DECIMAL_DIGITS-1-i) +: 4] != 4'd0) begin
				first_idx = IDX_W'(i);
			end
		end
		pt_ok  = !ctl_c[NSTG].zero && (ctl_c[NSTG].frac != 3'd0)
			&& (int'(ctl_c[NSTG].frac) < DECIMAL_DIGITS);
		pt_idx = pt_ok ? IDX_W'(DECIMAL_DIGITS - 1 - int'(ctl_c[NSTG].frac)) : '0;
		if (ctl_c[NSTG].zero) begin
			st_idx = LAST_IDX;
		end else if (pt_ok && (pt_idx < first_idx)) begin
			st_idx = pt_idx;
		end else begin
			st_idx = first_idx;
		end
	end

	assign rdy_s9 = !v_s9 || em_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (rdy_s9) begin
			v_s9 <= v_c[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (v_c[NSTG] && rdy_s9) begin
			dig_s9       <= bcd_c[NSTG];
			fmt_s9.neg   <= ctl_c[NSTG].neg;
			fmt_s9.pt_ok <= pt_ok;
			st_s9        <= st_idx;
			pt_s9        <= pt_idx;
		end
	end

	// Character sequencer and output register.
	sitda_emitter #(
		.DIGITS(DECIMAL_DIGITS),
		.IDX_W (IDX_W)
	) u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_ready (em_ready),
		.in_digits(dig_s9),
		.in_fmt   (fmt_s9),
		.in_start (st_s9),
		.in_point (pt_s9),
		.out_valid(dst_valid),
		.out_stall(dst_stall),
		.out_char (char_code),
		.out_last (last_char)
	);

	// A sign or a point is never the final character of a word.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && ((char_code == CHAR_MINUS) || (char_code == CHAR_POINT)) |-> !last_char)
		else $error("sign or point flagged as last character");

	// A held front stage keeps its magnitude.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s0 && !rdy_c[0] |=> v_s0 && $stable(mag_s0))
		else $error("front stage lost its word under stall");

	// The point never follows the units digit, and printing never starts after the point.
	a_point_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 && fmt_s9.pt_ok |-> (pt_s9 < LAST_IDX) && (st_s9 <= pt_s9))
		else $error("point position out of range");

endmodule

`default_nettype wire

/* bench/decimal_ascii_checker.sv */
`default_nettype none

module decimal_ascii_checker
	import sitda_pkg::*;
#(
	parameter int DIGITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	input  wire logic        src_stall,
	input  wire logic [31:0] value,
	input  wire logic [2:0]  fraction_digits,
	input  wire logic        dst_valid,
	input  wire logic        dst_stall,
	input  wire logic [6:0]  char_code,
	input  wire logic        last_char,
	output int               fail_count,
	output int               chars_pending
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} ascii_char_t;

	// Characters still owed by the block, oldest first.
	ascii_char_t expected_chars[$];

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	function automatic void push_char(input logic [6:0] code);
		ascii_char_t ch;
		ch.code = code;
		ch.last = 1'b0;
		expected_chars.push_back(ch);
	endfunction

	// Builds the character string of one word and queues it.
	function automatic void format_decimal(input logic [31:0] num, input logic [2:0] frac);
		logic            neg;
		logic [31:0]     mag32;
		longint unsigned mag;
		longint unsigned top;
		longint unsigned div;
		longint unsigned digit;
		int              point_pos;
		bit              started;
		neg = num[31];
		mag32 = neg ? (~num + 32'd1) : num;
		mag = longint'(mag32);
		if (mag == 0) begin
			push_char(CHAR_ZERO);
		end else begin
			top = 1;
			for (int i = 1; i < DIGITS; i++) begin
				top = top * 10;
			end
			if (neg) begin
				push_char(CHAR_MINUS);
			end
			// Magnitudes that do not fit the digit count saturate to all nines.
			if (mag > top * 10 - 1) begin
				mag = top * 10 - 1;
			end
			point_pos = DIGITS - int'(frac);
			started = 1'b0;
			div = top;
			for (int pos = 1; pos < DIGITS; pos++) begin
				digit = mag / div;
				mag = mag % div;
				if (digit != 0 || started) begin
					push_char(CHAR_ZERO + 7'(digit));
					started = 1'b1;
				end
				// A point with nothing before it gets a single leading zero.
				if (pos == point_pos) begin
					if (!started) begin
						push_char(CHAR_ZERO);
					end
					push_char(CHAR_POINT);
					started = 1'b1;
				end
				div = div / 10;
			end
			push_char(CHAR_ZERO + 7'(mag));
		end
		expected_chars[expected_chars.size() - 1].last = 1'b1;
	endfunction

	// Predict on every accepted word and compare every accepted character.
	always @(posedge clk) begin
		ascii_char_t want;
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				format_decimal(value, fraction_digits);
			end
			if (dst_valid && !dst_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("char 0x%02h arrived with none expected",
						char_code));
				end else begin
					want = expected_chars.pop_front();
					if (char_code !== want.code) begin
						report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
							char_code, want.code));
					end
					if (last_char !== want.last) begin
						report_mismatch($sformatf("last_char %b, expected %b",
							last_char, want.last));
					end
				end
			end
			chars_pending <= expected_chars.size();
		end
	end

endmodule

`default_nettype wire

/* bench/signed_int_to_decimal_ascii_core_test.sv */
`default_nettype none

module signed_int_to_decimal_ascii_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGITS      = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [31:0] value = '0;
	logic [2:0]  fraction_digits = '0;
	logic        dst_valid;
	logic        dst_stall = 1'b0;
	logic [6:0]  char_code;
	logic        last_char;

	int fail_count;
	int chars_pending;
	int cycle_count = 0;
	int hold_left = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	signed_int_to_decimal_ascii_core #(
		.DECIMAL_DIGITS(DIGITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.value(value),
		.fraction_digits(fraction_digits),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.char_code(char_code),
		.last_char(last_char)
	);

	decimal_ascii_checker #(
		.DIGITS(DIGITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.value(value),
		.fraction_digits(fraction_digits),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.char_code(char_code),
		.last_char(last_char),
		.fail_count(fail_count),
		.chars_pending(chars_pending)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up if the run takes far longer than any correct run could.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Output side: random stalls, and one long hold-off when asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				dst_stall <= 1'b1;
				hold_left--;
			end else begin
				dst_stall <= idle_on && ($urandom_range(0, 99) < 26);
			end
		end
	end

	// Offers one word and returns once the block has taken it.
	task automatic send_word(input logic [31:0] num, input logic [2:0] frac);
		while (idle_on && ($urandom_range(0, 99) < 26)) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		value <= num;
		fraction_digits <= frac;
		@(posedge clk);
		while (src_stall) begin
			@(posedge clk);
		end
	endtask

	// Mix of full-range values, in-range magnitudes, short numbers, values at and
	// next to a power of ten, extreme values and zero, with either sign.
	function automatic logic [31:0] pick_number();
		logic [31:0]     num;
		longint unsigned p;
		int unsigned     k;
		case ($urandom_range(0, 5))
			0: num = $urandom;
			1: num = $urandom_range(0, 99999999);
			2: num = $urandom_range(0, 999);
			3: begin
				k = $urandom_range(1, 9);
				p = 1;
				repeat (k) p = p * 10;
				num = 32'(p) + 32'($urandom_range(0, 2)) - 32'd1;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: num = 32'h7FFF_FFFF;
					1: num = 32'h8000_0000;
					2: num = 32'd99999999;
					default: num = 32'd100000000;
				endcase
			end
			default: num = '0;
		endcase
		if ($urandom_range(0, 1) == 1) begin
			num = -num;
		end
		return num;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero, saturation, the most negative value, points near both ends
		// and points that need a leading zero.
		send_word(32'd0, 3'd0);
		send_word(32'd0, 3'd7);
		send_word(32'd1, 3'd0);
		send_word(32'hFFFF_FFFF, 3'd0);
		send_word(32'hFFFF_FFFF, 3'd7);
		send_word(32'd5, 3'd7);
		send_word(-32'sd5, 3'd7);
		send_word(32'd12, 3'd2);
		send_word(32'd123, 3'd2);
		send_word(32'd1, 3'd1);
		send_word(32'd10, 3'd1);
		send_word(32'd12345678, 3'd4);
		send_word(32'd99999999, 3'd0);
		send_word(-32'sd99999999, 3'd7);
		send_word(32'd100000000, 3'd0);
		send_word(32'h7FFF_FFFF, 3'd0);
		send_word(32'h7FFF_FFFF, 3'd7);
		send_word(32'h8000_0000, 3'd0);
		send_word(32'h8000_0000, 3'd3);
		send_word(32'h5555_5555, 3'd5);
		send_word(32'hAAAA_AAAA, 3'd6);
		send_word(32'd9, 3'd1);

		// Hold the output for a long time so the pipeline fills and the
		// input side has to stall.
		idle_on = 1'b0;
		hold_req = 1'b1;
		repeat (40) send_word(pick_number(), 3'($urandom_range(0, 7)));
		idle_on = 1'b1;

		// Random words, with a stretch in the middle where neither side idles.
		for (int n = 0; n < 260; n++) begin
			idle_on = !(n >= 100 && n < 160);
			send_word(pick_number(), 3'($urandom_range(0, 7)));
		end
		idle_on = 1'b1;
		src_valid <= 1'b0;

		// Drain, then watch a while longer for stray characters.
		@(posedge clk);
		while (chars_pending != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);

		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
